/* design/gpbm_pkg.sv */
`timescale 1ns / 1ps

package gpbm_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_CTRL  = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_READ   = 2'd1,
    ACT_WRITE  = 2'd2,
    ACT_DIRECT = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    TGT_GRAM  = 3'd0,
    TGT_CRAM  = 3'd1,
    TGT_DSR   = 3'd2,
    TGT_GROMA = 3'd3,
    TGT_GROMB = 3'd4,
    TGT_ROM6  = 3'd5
  } target_e;

  // control flag positions
  localparam logic [3:0] F_DSR   = 4'd0;
  localparam logic [3:0] F_GRAM  = 4'd1;
  localparam logic [3:0] F_BANK  = 4'd2;
  localparam logic [3:0] F_CARD  = 4'd3;
  localparam logic [3:0] F_WRITE = 4'd4;
  localparam logic [3:0] F_LED   = 4'd6;
  localparam logic [3:0] F_FREE  = 4'd7;
  localparam logic [3:0] F_MBX   = 4'd8;
  localparam logic [3:0] F_RAM   = 4'd9;

  localparam logic [9:0] FLAGS_RESET = 10'b00_0000_1100;

  // control bit numbers
  localparam logic [3:0] CBIT_PAGE_LO = 4'd3;
  localparam logic [3:0] CBIT_PAGE_HI = 4'd8;
  localparam logic [3:0] CBIT_FREE    = 4'd13;
  localparam logic [3:0] CBIT_SKIP    = 4'd6;

  // address windows
  localparam logic [7:0]  CTL_BASE     = 8'h1B;
  localparam logic [5:0]  WIN_DSR      = 6'b111010;  // 0x74000 / 0x7e000
  localparam logic [5:0]  WIN_CART     = 6'b111011;  // 0x76000 / 0x7e000
  localparam logic [8:0]  WIN_GROM_RD  = 9'h1E6;     // 0x79800 / 0x7fc01
  localparam logic [8:0]  WIN_GROM_WR  = 9'h1E7;     // 0x79c00 / 0x7fc01
  localparam logic [15:0] MBX_BANK_REG = 16'h6FFE;
  localparam logic [5:0]  MBX_RAM_WIN  = 6'b011011;  // 0x6c00 / 0xfc00

  // port numbers
  localparam logic [7:0] PORT_GRAM_END  = 8'd2;
  localparam logic [7:0] PORT_GROMA_END = 8'd8;
  localparam logic [7:0] PORT_GROMB_END = 8'd16;
  localparam logic [7:0] PORT_DSR_END   = 8'd24;
  localparam logic [7:0] PORT_ROM6_END  = 8'd32;
  localparam logic [7:0] PORT_GRAM2_LO  = 8'd32;
  localparam logic [7:0] PORT_GRAM2_HI  = 8'd33;
  localparam logic [7:0] PORT_CRAM_LO   = 8'd48;
  localparam logic [7:0] PORT_CRAM_HI   = 8'd49;

endpackage

/* design/gpl_port_bank_mapper.sv */
`timescale 1ns / 1ps

// a result is presented on the output register in the cycle after its item is accepted
// throughput: one item per cycle; decode and counter update sit between input and result regs
// a waiting result does not block input as long as the consumer takes it in the same cycle
// reset (rst_ni low, async): address counter, byte toggles, port, bank and page cleared,
// control flags back to bank and card enable, flash mode off, output register empty
module gpl_port_bank_mapper (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // bus access items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [18:0] address_i,
  input  logic [7:0]  write_data_i,
  // decoded results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  action_o,
  output logic [2:0]  target_o,
  output logic [18:0] mem_address_o,
  output logic [7:0]  mem_write_data_o,
  output logic [7:0]  direct_read_data_o,
  output logic        led_lit_o
);

  // architectural state
  logic        flash_mode_q;
  logic [15:0] gpl_q, gpl_d;
  logic        rd_low_q, rd_low_d;
  logic        wr_low_q, wr_low_d;
  logic [7:0]  port_q, port_d;
  logic [1:0]  bank_q, bank_d;
  logic [5:0]  page_q, page_d;
  logic [9:0]  flags_q, flags_d;

  // output register
  logic        out_valid_q;
  logic [1:0]  action_q;
  logic [2:0]  target_q;
  logic [18:0] maddr_q;
  logic [7:0]  mwdata_q;
  logic [7:0]  rdata_q;
  logic        led_q;

  logic        in_fire;

  // result of this item
  gpbm_pkg::action_e act;
  gpbm_pkg::target_e tgt;
  logic [18:0] maddr;
  logic [7:0]  mwdata;
  logic [7:0]  rdata;

  // decode helpers
  logic [15:0] off;
  logic [7:0]  gport;       // port selected by a GROM window access
  logic        win_dsr, win_cart, win_grom_rd, win_grom_wr;
  logic        gd_block;    // flash mode hides bank A on reads
  logic        gd_hit;
  gpbm_pkg::target_e gd_tgt;
  logic [18:0] gd_addr;
  logic        cr_hit;
  logic [18:0] cr_addr;
  logic [18:0] rom6_addr;
  logic [15:0] gpl_inc;
  logic [3:0]  cbit;
  logic [3:0]  fbit;

  // one slot of output buffering; refills in the cycle it drains
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign off         = address_i[15:0];
  assign gport       = address_i[9:2];
  assign win_dsr     = address_i[18:13] == gpbm_pkg::WIN_DSR;
  assign win_cart    = address_i[18:13] == gpbm_pkg::WIN_CART;
  assign win_grom_rd = (address_i[18:10] == gpbm_pkg::WIN_GROM_RD) && !address_i[0];
  assign win_grom_wr = (address_i[18:10] == gpbm_pkg::WIN_GROM_WR) && !address_i[0];
  assign gpl_inc     = gpl_q + 16'd1;
  assign cbit        = address_i[4:1];
  assign fbit        = (cbit < gpbm_pkg::CBIT_PAGE_LO) ? cbit : cbit - gpbm_pkg::CBIT_SKIP;

  assign gd_block = (opcode_i == gpbm_pkg::OP_READ) && flash_mode_q;

  // GROM data port decode; every flash/GRAM target takes the low three port bits as 64K page
  always_comb begin
    gd_hit  = 1'b1;
    gd_tgt  = gpbm_pkg::TGT_GRAM;
    gd_addr = {gport[2:0], gpl_q};
    priority if (gport < gpbm_pkg::PORT_GRAM_END && flags_q[gpbm_pkg::F_GRAM]) begin
      gd_tgt = gpbm_pkg::TGT_GRAM;
    end else if (gport < gpbm_pkg::PORT_GROMA_END) begin
      gd_tgt = gpbm_pkg::TGT_GROMA;
      gd_hit = !gd_block;
    end else if (gport < gpbm_pkg::PORT_GROMB_END) begin
      gd_tgt = gpbm_pkg::TGT_GROMB;
    end else if (gport < gpbm_pkg::PORT_DSR_END) begin
      gd_tgt = gpbm_pkg::TGT_DSR;
    end else if (gport < gpbm_pkg::PORT_ROM6_END) begin
      gd_tgt = gpbm_pkg::TGT_ROM6;
    end else if (gport == gpbm_pkg::PORT_GRAM2_LO || gport == gpbm_pkg::PORT_GRAM2_HI) begin
      gd_tgt = gpbm_pkg::TGT_GRAM;
    end else if (gport == gpbm_pkg::PORT_CRAM_LO || gport == gpbm_pkg::PORT_CRAM_HI) begin
      gd_tgt  = gpbm_pkg::TGT_CRAM;
      gd_addr = {3'b000, gpl_q};
    end else begin
      gd_hit = 1'b0;
    end
  end

  // cartridge RAM decode through the current port: 8K bank, 32K half by port bit 0
  always_comb begin
    cr_addr = {3'b000, port_q[0], bank_q, off[12:0]};
    cr_hit  = (port_q < gpbm_pkg::PORT_GRAM_END && flags_q[gpbm_pkg::F_RAM])
           || port_q == gpbm_pkg::PORT_GRAM2_LO || port_q == gpbm_pkg::PORT_GRAM2_HI;
  end

  // flash ports map cartridge space into ROM6 flash, 32K per port
  assign rom6_addr = {port_q[3:0], bank_q, off[12:0]};

  // main decode and state update
  always_comb begin
    gpl_d    = gpl_q;
    rd_low_d = rd_low_q;
    wr_low_d = wr_low_q;
    port_d   = port_q;
    bank_d   = bank_q;
    page_d   = page_q;
    flags_d  = flags_q;
    act      = gpbm_pkg::ACT_NONE;
    tgt      = gpbm_pkg::TGT_GRAM;
    maddr    = '0;
    mwdata   = '0;
    rdata    = '0;

    unique case (opcode_i)
      gpbm_pkg::OP_READ: begin
        if (win_dsr) begin
          if (flags_q[gpbm_pkg::F_DSR]) begin
            act   = gpbm_pkg::ACT_READ;
            tgt   = gpbm_pkg::TGT_DSR;
            maddr = {page_q, off[12:0]};
          end
        end else if (win_cart) begin
          if (flags_q[gpbm_pkg::F_CARD] && !flash_mode_q) begin
            if (cr_hit) begin
              act   = gpbm_pkg::ACT_READ;
              tgt   = gpbm_pkg::TGT_CRAM;
              maddr = cr_addr;
            end else if (port_q < gpbm_pkg::PORT_GROMB_END) begin
              act   = gpbm_pkg::ACT_READ;
              tgt   = gpbm_pkg::TGT_ROM6;
              maddr = rom6_addr;
            end
          end
        end else if (win_grom_rd) begin
          port_d = gport;
          if (off[1]) begin
            // address read-back: high byte first, of counter plus one
            wr_low_d = 1'b0;
            act      = gpbm_pkg::ACT_DIRECT;
            if (rd_low_q) begin
              rdata    = gpl_inc[7:0];
              rd_low_d = 1'b0;
            end else begin
              rdata    = gpl_inc[15:8];
              rd_low_d = 1'b1;
            end
          end else begin
            // data read: counter advances even with nothing behind the port
            gpl_d    = gpl_inc;
            rd_low_d = 1'b0;
            wr_low_d = 1'b0;
            if (flags_q[gpbm_pkg::F_CARD] && gd_hit) begin
              act   = gpbm_pkg::ACT_READ;
              tgt   = gd_tgt;
              maddr = gd_addr;
            end
          end
        end
      end

      gpbm_pkg::OP_WRITE: begin
        if (win_cart) begin
          if (flags_q[gpbm_pkg::F_CARD] && !flash_mode_q) begin
            priority if (flags_q[gpbm_pkg::F_BANK]) begin
              bank_d = off[2:1];
            end else if (flags_q[gpbm_pkg::F_MBX] && off == gpbm_pkg::MBX_BANK_REG) begin
              bank_d = write_data_i[1:0];
            end else if (flags_q[gpbm_pkg::F_WRITE] || (flags_q[gpbm_pkg::F_MBX]
                         && off[15:10] == gpbm_pkg::MBX_RAM_WIN)) begin
              if (cr_hit) begin
                act    = gpbm_pkg::ACT_WRITE;
                tgt    = gpbm_pkg::TGT_CRAM;
                maddr  = cr_addr;
                mwdata = write_data_i;
              end
            end else begin
              // cartridge flash writes are not handled
            end
          end
        end else if (win_grom_wr) begin
          port_d = gport;
          if (off[1]) begin
            // address load: high byte, then low byte
            rd_low_d = 1'b0;
            if (wr_low_q) begin
              gpl_d    = {gpl_q[15:8], write_data_i};
              wr_low_d = 1'b0;
            end else begin
              gpl_d    = {write_data_i, gpl_q[7:0]};
              wr_low_d = 1'b1;
            end
          end else begin
            gpl_d    = gpl_inc;
            rd_low_d = 1'b0;
            wr_low_d = 1'b0;
            if (flags_q[gpbm_pkg::F_CARD] && flags_q[gpbm_pkg::F_WRITE] && gd_hit) begin
              act    = gpbm_pkg::ACT_WRITE;
              tgt    = gd_tgt;
              maddr  = gd_addr;
              mwdata = write_data_i;
            end
          end
        end
      end

      gpbm_pkg::OP_CTRL: begin
        if (off[15:8] == gpbm_pkg::CTL_BASE) begin
          if (cbit >= gpbm_pkg::CBIT_PAGE_LO && cbit <= gpbm_pkg::CBIT_PAGE_HI) begin
            page_d[3'(cbit - gpbm_pkg::CBIT_PAGE_LO)] = write_data_i[0];
          end else if (cbit != gpbm_pkg::CBIT_FREE) begin
            flags_d[fbit] = write_data_i[0];
          end
        end
      end

      default: begin
        // undefined opcode: no effect
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      flash_mode_q <= cfg_wdata_i;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpl_q    <= '0;
      rd_low_q <= 1'b0;
      wr_low_q <= 1'b0;
      port_q   <= '0;
      bank_q   <= '0;
      page_q   <= '0;
      flags_q  <= gpbm_pkg::FLAGS_RESET;
    end else if (in_fire) begin
      gpl_q    <= gpl_d;
      rd_low_q <= rd_low_d;
      wr_low_q <= wr_low_d;
      port_q   <= port_d;
      bank_q   <= bank_d;
      page_q   <= page_d;
      flags_q  <= flags_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // output payload, loaded with each accepted item
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      action_q <= act;
      target_q <= tgt;
      maddr_q  <= maddr;
      mwdata_q <= mwdata;
      rdata_q  <= rdata;
      led_q    <= flags_d[gpbm_pkg::F_LED];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign action_o           = action_q;
  assign target_o           = target_q;
  assign mem_address_o      = maddr_q;
  assign mem_write_data_o   = mwdata_q;
  assign direct_read_data_o = rdata_q;
  assign led_lit_o          = led_q;

`ifndef NO_ASSERTIONS
  // every accepted item leaves a result behind
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted item produced no result");

  // target and address only carry meaning with a memory request
  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && action_q != gpbm_pkg::ACT_READ && action_q != gpbm_pkg::ACT_WRITE
    |-> target_q == gpbm_pkg::TGT_GRAM && maddr_q == '0)
    else $error("target or address set without memory request");

  // read-back byte only with a direct read
  a_rdata_only_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && action_q != gpbm_pkg::ACT_DIRECT |-> rdata_q == '0)
    else $error("read-back data outside direct read");

  // an address read-back does not move the counter
  a_readback_keeps_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && opcode_i == gpbm_pkg::OP_READ && win_grom_rd && off[1] |=> $stable(gpl_q))
    else $error("address counter moved on read-back");

  // the free control bit never gets set
  a_free_flag_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !flags_q[gpbm_pkg::F_FREE])
    else $error("free control flag set");
`endif

endmodule

/* tb/sv/gpl_port_bank_mapper_test.sv */
`timescale 1ns / 1ps

module gpl_port_bank_mapper_test;
  import gpbm_pkg::*;

  // opcode with no meaning, used to check that it is ignored
  localparam logic [1:0] OP_UNDEF = 2'd3;

  // address windows of the bus
  localparam logic [18:0] PAGE_WIN_MASK = 19'h7E000;
  localparam logic [18:0] DSR_BASE      = 19'h74000;
  localparam logic [18:0] CART_BASE     = 19'h76000;
  localparam logic [18:0] GROM_WIN_MASK = 19'h7FC01;
  localparam logic [18:0] GROM_RD_BASE  = 19'h79800;
  localparam logic [18:0] GROM_WR_BASE  = 19'h79C00;

  // control bit numbers as seen on the bus
  localparam logic [3:0] CB_DSR   = 4'd0;
  localparam logic [3:0] CB_BANK  = 4'd2;
  localparam logic [3:0] CB_PAGE0 = 4'd3;
  localparam logic [3:0] CB_PAGE5 = 4'd8;
  localparam logic [3:0] CB_CARD  = 4'd9;
  localparam logic [3:0] CB_WRITE = 4'd10;
  localparam logic [3:0] CB_LED   = 4'd12;
  localparam logic [3:0] CB_FREE  = 4'd13;
  localparam logic [3:0] CB_MBX   = 4'd14;
  localparam logic [3:0] CB_RAM   = 4'd15;

  // one decoded bus request
  typedef struct {
    action_e     act;
    target_e     tgt;
    logic [18:0] maddr;
    logic [7:0]  wdata;
    logic [7:0]  rdata;
    logic        led;
  } bus_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  opcode_i;
  logic [18:0] address_i;
  logic [7:0]  write_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  action_o;
  logic [2:0]  target_o;
  logic [18:0] mem_address_o;
  logic [7:0]  mem_write_data_o;
  logic [7:0]  direct_read_data_o;
  logic        led_lit_o;

  // mirror of the card state, kept in step with accepted items
  logic [15:0] grom_addr;
  logic        rd_low_pending;
  logic        wr_low_pending;
  logic [7:0]  cur_port;
  logic [1:0]  bank_mirror;
  logic [5:0]  page_mirror;
  logic [9:0]  card_flags;
  logic        flash_only;

  // decoded requests still owed by the block, oldest first
  bus_result_t pending_results[$];

  int mismatches   = 0;
  int items_sent   = 0;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int rx_hold_left = 0;

  gpl_port_bank_mapper u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .opcode_i           (opcode_i),
    .address_i          (address_i),
    .write_data_i       (write_data_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .action_o           (action_o),
    .target_o           (target_o),
    .mem_address_o      (mem_address_o),
    .mem_write_data_o   (mem_write_data_o),
    .direct_read_data_o (direct_read_data_o),
    .led_lit_o          (led_lit_o)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // card state mirror
  // ---------------------------------------------------------------------------

  task automatic reset_card_state();
    grom_addr      = '0;
    rd_low_pending = 1'b0;
    wr_low_pending = 1'b0;
    cur_port       = '0;
    bank_mirror    = '0;
    page_mirror    = '0;
    card_flags     = FLAGS_RESET;
    flash_only     = 1'b0;
  endtask

  // grom data port lookup; 0 when no memory sits behind the current port
  function automatic bit grom_lookup(input bit is_read, output target_e t,
                                     output logic [18:0] a);
    a = {cur_port[2:0], grom_addr};
    t = TGT_GRAM;
    if (cur_port < PORT_GRAM_END && card_flags[F_GRAM]) return 1'b1;
    if (cur_port < PORT_GROMA_END) begin
      // flash-only mode hides bank a reads, writes still go through
      t = TGT_GROMA;
      return !(is_read && flash_only);
    end
    if (cur_port < PORT_GROMB_END) begin
      t = TGT_GROMB;
      return 1'b1;
    end
    if (cur_port < PORT_DSR_END) begin
      t = TGT_DSR;
      return 1'b1;
    end
    if (cur_port < PORT_ROM6_END) begin
      t = TGT_ROM6;
      return 1'b1;
    end
    if (cur_port == PORT_GRAM2_LO || cur_port == PORT_GRAM2_HI) return 1'b1;
    if (cur_port == PORT_CRAM_LO || cur_port == PORT_CRAM_HI) begin
      t = TGT_CRAM;
      a = {3'b000, grom_addr};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // cartridge ram lookup for ram ports; 0 for flash ports and holes
  function automatic bit cart_ram_lookup(input logic [15:0] off, output logic [18:0] a);
    a = {3'b000, cur_port[0], bank_mirror, off[12:0]};
    if (cur_port < PORT_GRAM_END && card_flags[F_RAM]) return 1'b1;
    if (cur_port < PORT_GROMB_END) return 1'b0;
    return (cur_port == PORT_GRAM2_LO || cur_port == PORT_GRAM2_HI);
  endfunction

  // data port access moves the counter on and restarts both byte toggles
  function automatic void step_grom_counter();
    grom_addr      = grom_addr + 16'd1;
    rd_low_pending = 1'b0;
    wr_low_pending = 1'b0;
  endfunction

  // decode one bus access and update the mirror
  function automatic bus_result_t decode_access(logic [1:0] op, logic [18:0] addr,
                                                logic [7:0] data);
    bus_result_t r;
    logic [15:0] off;
    logic [15:0] nxt;
    logic [18:0] a;
    logic [3:0]  cbit;
    logic [3:0]  fb;
    target_e     t;
    bit          hit;
    r.act   = ACT_NONE;
    r.tgt   = TGT_GRAM;
    r.maddr = '0;
    r.wdata = '0;
    r.rdata = '0;
    off     = addr[15:0];
    if (op == OP_READ) begin
      if ((addr & PAGE_WIN_MASK) == DSR_BASE) begin
        if (card_flags[F_DSR]) begin
          r.act   = ACT_READ;
          r.tgt   = TGT_DSR;
          r.maddr = {page_mirror, off[12:0]};
        end
      end else if ((addr & PAGE_WIN_MASK) == CART_BASE) begin
        if (card_flags[F_CARD] && !flash_only) begin
          if (cart_ram_lookup(off, a)) begin
            r.act   = ACT_READ;
            r.tgt   = TGT_CRAM;
            r.maddr = a;
          end else if (cur_port < PORT_GROMB_END) begin
            r.act   = ACT_READ;
            r.tgt   = TGT_ROM6;
            r.maddr = {cur_port[3:0], bank_mirror, off[12:0]};
          end
        end
      end else if ((addr & GROM_WIN_MASK) == GROM_RD_BASE) begin
        cur_port = off[9:2];
        if (off[1]) begin
          // address read-back shows the counter plus one, high byte first
          nxt            = grom_addr + 16'd1;
          wr_low_pending = 1'b0;
          r.act          = ACT_DIRECT;
          r.rdata        = rd_low_pending ? nxt[7:0] : nxt[15:8];
          rd_low_pending = !rd_low_pending;
        end else begin
          hit = 1'b0;
          if (card_flags[F_CARD]) hit = grom_lookup(1'b1, t, a);
          step_grom_counter();
          if (hit) begin
            r.act   = ACT_READ;
            r.tgt   = t;
            r.maddr = a;
          end
        end
      end
    end else if (op == OP_WRITE) begin
      if ((addr & PAGE_WIN_MASK) == CART_BASE) begin
        if (card_flags[F_CARD] && !flash_only) begin
          if (card_flags[F_BANK]) begin
            bank_mirror = off[2:1];
          end else if (card_flags[F_MBX] && off == MBX_BANK_REG) begin
            bank_mirror = data[1:0];
          end else if (card_flags[F_WRITE] ||
                       (card_flags[F_MBX] && off[15:10] == MBX_RAM_WIN)) begin
            if (cart_ram_lookup(off, a)) begin
              r.act   = ACT_WRITE;
              r.tgt   = TGT_CRAM;
              r.maddr = a;
              r.wdata = data;
            end
          end
        end
      end else if ((addr & GROM_WIN_MASK) == GROM_WR_BASE) begin
        cur_port = off[9:2];
        if (off[1]) begin
          // address load: high byte, then low byte
          rd_low_pending = 1'b0;
          if (wr_low_pending) grom_addr[7:0] = data;
          else grom_addr[15:8] = data;
          wr_low_pending = !wr_low_pending;
        end else begin
          hit = 1'b0;
          if (card_flags[F_CARD] && card_flags[F_WRITE]) hit = grom_lookup(1'b0, t, a);
          step_grom_counter();
          if (hit) begin
            r.act   = ACT_WRITE;
            r.tgt   = t;
            r.maddr = a;
            r.wdata = data;
          end
        end
      end
    end else if (op == OP_CTRL) begin
      if (addr[15:8] == CTL_BASE) begin
        cbit = addr[4:1];
        if (cbit >= CBIT_PAGE_LO && cbit <= CBIT_PAGE_HI) begin
          page_mirror[3'(cbit - CBIT_PAGE_LO)] = data[0];
        end else if (cbit != CBIT_FREE) begin
          fb = (cbit < CBIT_PAGE_LO) ? cbit : cbit - CBIT_SKIP;
          card_flags[fb] = data[0];
        end
      end
    end
    r.led = card_flags[F_LED];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [18:0] want, logic [18:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // every result taken by the receiver is matched against the oldest request
  always @(posedge clk_i) begin
    bus_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing outstanding, expected none actual action %0d",
                 $time, action_o);
      end else begin
        want = pending_results.pop_front();
        check_field("action", 19'(want.act), 19'(action_o));
        check_field("target", 19'(want.tgt), 19'(target_o));
        check_field("mem_address", want.maddr, mem_address_o);
        check_field("mem_write_data", 19'(want.wdata), 19'(mem_write_data_o));
        check_field("direct_read_data", 19'(want.rdata), 19'(direct_read_data_o));
        check_field("led_lit", 19'(want.led), 19'(led_lit_o));
      end
    end
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one item, with a random gap in front, and hold it until taken
  task automatic send_access(logic [1:0] op, logic [18:0] addr, logic [7:0] data);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    address_i    <= addr;
    write_data_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(decode_access(op, addr, data));
    items_sent++;
  endtask

  // sender goes quiet until every owed result has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // only called with the block idle
  task automatic write_flash_mode(logic value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    flash_only   = value;
  endtask

  // control bit address with the don't-care bits scrambled
  function automatic logic [18:0] ctl_addr(logic [3:0] cbit);
    logic [18:0] a;
    a       = 19'($urandom);
    a[15:8] = CTL_BASE;
    a[4:1]  = cbit;
    return a;
  endfunction

  function automatic logic [18:0] grom_port_addr(logic [7:0] port, bit is_write,
                                                 bit addr_reg);
    return (is_write ? GROM_WR_BASE : GROM_RD_BASE) | {9'd0, port, addr_reg, 1'b0};
  endfunction

  function automatic logic [18:0] cart_addr(logic [12:0] low);
    return CART_BASE | 19'(low);
  endfunction

  function automatic logic [18:0] dsr_addr(logic [12:0] low);
    return DSR_BASE | 19'(low);
  endfunction

  // ports weighted so every region, and the holes between them, gets hit
  function automatic logic [7:0] pick_port();
    case ($urandom_range(9))
      0: return 8'($urandom_range(1));
      1: return 8'($urandom_range(7, 2));
      2: return 8'($urandom_range(15, 8));
      3: return 8'($urandom_range(23, 16));
      4: return 8'($urandom_range(31, 24));
      5: return 8'($urandom_range(33, 32));
      6: return 8'($urandom_range(49, 48));
      7: return 8'($urandom_range(47, 34));
      8: return 8'($urandom_range(255, 50));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // mostly well-formed accesses with random content, some raw noise
  task automatic send_random_access();
    int          pick;
    logic [7:0]  port;
    logic [7:0]  data;
    logic [12:0] low;
    logic [3:0]  cbit;
    pick = $urandom_range(99);
    port = pick_port();
    data = 8'($urandom_range(255));
    low  = 13'($urandom_range(8191));
    cbit = 4'($urandom_range(15));
    if (pick < 12) begin
      // keep the card mostly enabled so data accesses stay interesting
      if (cbit == CB_CARD) data[0] = ($urandom_range(4) != 0);
      send_access(OP_CTRL, ctl_addr(cbit), data);
    end else if (pick < 22) begin
      send_access(OP_WRITE, grom_port_addr(port, 1'b1, 1'b1), data);
      send_access(OP_WRITE, grom_port_addr(port, 1'b1, 1'b1), 8'($urandom_range(255)));
    end else if (pick < 42) begin
      send_access(OP_READ, grom_port_addr(port, 1'b0, 1'b0), data);
    end else if (pick < 55) begin
      send_access(OP_WRITE, grom_port_addr(port, 1'b1, 1'b0), data);
    end else if (pick < 62) begin
      send_access(OP_READ, grom_port_addr(port, 1'b0, 1'b1), data);
    end else if (pick < 70) begin
      send_access(OP_READ, dsr_addr(low), data);
    end else if (pick < 80) begin
      send_access(OP_READ, cart_addr(low), data);
    end else if (pick < 90) begin
      // aim some cartridge writes at the mbx bank register and ram window
      case ($urandom_range(4))
        0: low = MBX_BANK_REG[12:0];
        1: low[12:10] = MBX_RAM_WIN[2:0];
        default: ;
      endcase
      send_access(OP_WRITE, cart_addr(low), data);
    end else begin
      send_access(2'($urandom_range(3)), 19'($urandom), data);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // undefined opcode, unmatched address and control bit handling
  task automatic test_control_bits();
    logic [18:0] off_base;
    off_base        = ctl_addr(CB_WRITE);
    off_base[15:8]  = CTL_BASE ^ 8'h01;
    send_access(OP_UNDEF, 19'h7FFFF, 8'hFF);
    send_access(OP_READ, 19'h00000, 8'h00);
    send_access(OP_CTRL, off_base, 8'h01);           // outside the card base
    send_access(OP_CTRL, ctl_addr(CB_FREE), 8'hFF);  // free bit stays clear
    send_access(OP_CTRL, ctl_addr(CB_LED), 8'h01);
    send_access(OP_CTRL, ctl_addr(CB_DSR), 8'h01);
    send_access(OP_CTRL, ctl_addr(CB_PAGE0), 8'h01);
    send_access(OP_CTRL, ctl_addr(CB_PAGE5), 8'h01);
    send_access(OP_READ, dsr_addr(13'h1FFF), 8'h00);
  endtask

  // address load, read-back, counter wrap, disabled card, undefined port
  task automatic test_grom_counter();
    send_access(OP_WRITE, grom_port_addr(8'd0, 1'b1, 1'b1), 8'hFF);
    send_access(OP_WRITE, grom_port_addr(8'd0, 1'b1, 1'b1), 8'hFF);
    send_access(OP_READ, grom_port_addr(8'd0, 1'b0, 1'b1), 8'h00);
    send_access(OP_READ, grom_port_addr(8'd7, 1'b0, 1'b0), 8'h00);  // wraps to zero
    send_access(OP_CTRL, ctl_addr(CB_CARD), 8'h00);
    send_access(OP_READ, grom_port_addr(8'd1, 1'b0, 1'b0), 8'h00);  // counts, no request
    send_access(OP_CTRL, ctl_addr(CB_CARD), 8'h01);
    send_access(OP_CTRL, ctl_addr(CB_WRITE), 8'h01);
    send_access(OP_WRITE, grom_port_addr(8'hFF, 1'b1, 1'b0), 8'hA5);
    send_access(OP_WRITE, grom_port_addr(8'd33, 1'b1, 1'b0), 8'h5A);
  endtask

  // bank switching, mbx register, flash ports and ram ports in cartridge space
  task automatic test_cart_banking();
    send_access(OP_WRITE, cart_addr(13'h0006), 8'h00);
    send_access(OP_CTRL, ctl_addr(CB_BANK), 8'h00);
    send_access(OP_CTRL, ctl_addr(CB_MBX), 8'h01);
    send_access(OP_WRITE, cart_addr(MBX_BANK_REG[12:0]), 8'hFE);
    send_access(OP_READ, grom_port_addr(8'd5, 1'b0, 1'b1), 8'h00);
    send_access(OP_WRITE, cart_addr(13'h1FFF), 8'hFF);  // flash port, ram off
    send_access(OP_READ, cart_addr(13'h1FFF), 8'h00);
    send_access(OP_CTRL, ctl_addr(CB_RAM), 8'h01);
    send_access(OP_READ, grom_port_addr(8'd1, 1'b0, 1'b1), 8'h00);
    send_access(OP_WRITE, cart_addr(13'h0C00), 8'h3C);
  endtask

  task automatic test_random_traffic(int n_items, int tx_pct, int rx_pct);
    int stop_at;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at     = items_sent + n_items;
    while (items_sent < stop_at) send_random_access();
  endtask

  // cartridge space and bank a reads vanish in flash-only mode
  task automatic test_flash_mode();
    send_access(OP_READ, cart_addr(13'h0123), 8'h00);
    send_access(OP_READ, grom_port_addr(8'd3, 1'b0, 1'b0), 8'h00);
    send_access(OP_WRITE, grom_port_addr(8'd3, 1'b1, 1'b0), 8'h81);
    send_access(OP_WRITE, cart_addr(13'h0C02), 8'h18);
    test_random_traffic(150, 6, 56);
  endtask

  // long receiver hold-off so the output fills and the input stalls
  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    rx_hold_left = 60;
    repeat (30) send_random_access();
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 1'b0;
    in_valid_i   = 1'b0;
    opcode_i     = '0;
    address_i    = '0;
    write_data_i = '0;
    reset_card_state();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    write_flash_mode(1'b0);
    tx_idle_pct = 6;
    rx_idle_pct = 56;
    test_control_bits();
    test_grom_counter();
    test_cart_banking();
    drain_results();

    write_flash_mode(1'b1);
    test_flash_mode();
    drain_results();

    write_flash_mode(1'b0);
    test_random_traffic(250, 6, 56);
    test_random_traffic(250, 56, 6);
    test_backpressure();
    test_random_traffic(150, 0, 0);
    drain_results();

    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
